FILE: rtl/fpds_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the fractional-N PLL divider solver.
// No dependencies; used by frac_pll_divider_solver_core and the testbench.
package fpds_pkg;

  // Field widths
  localparam int RATE_W     = 32;
  localparam int REF_W      = 29;
  localparam int CODE_W     = 5;
  localparam int INT_W      = 11;
  localparam int FRAC_BITS  = 24;
  localparam int PRATE_W    = REF_W + 3;            // 8 * ref_rate
  localparam int DIVQ_W     = CODE_W + 2;           // (code+1)*2
  localparam int VCO_W      = RATE_W + DIVQ_W - 1;  // rate * divq, divq <= 64
  localparam int QUO_W      = INT_W + FRAC_BITS;    // multiplier quotient bits
  localparam int PRODF_W    = PRATE_W + FRAC_BITS;
  localparam int PRODI_W    = PRATE_W + INT_W;
  localparam int SUM_W      = PRODI_W + 1;
  localparam int ACH_NUM_W  = SUM_W - 1;            // sum with divq's factor 2 removed
  localparam int DEN2_W     = CODE_W + 1;           // code + 1

  localparam int MAX_DIV_CODE = 31;

  // Frequency limits in Hz
  localparam longint unsigned VCO_MIN_HZ = 64'd2000000000;
  localparam longint unsigned VCO_MAX_HZ = 64'd4000000000;
  localparam longint unsigned OUT_MIN_HZ = 64'd31250000;
  localparam longint unsigned OUT_MAX_HZ = 64'd2000000000;
  localparam longint unsigned REF_MIN_HZ = 64'd5000000;
  localparam longint unsigned REF_MAX_HZ = 64'd7500000;
  localparam logic [REF_W-1:0] REF_RESET = REF_W'(6000000);

  typedef struct packed {
    logic out_bad;
    logic ref_bad;
    logic vco_bad;
  } fpds_flags_t;

  // Sideband through the multiplier divider
  typedef struct packed {
    logic [CODE_W-1:0] code;
    fpds_flags_t       flags;
    logic              sat;
    logic              zero;
  } fpds_mid_t;

  // Sideband through the rate divider
  typedef struct packed {
    logic [CODE_W-1:0]    code;
    logic [INT_W-1:0]     int_mult;
    logic [FRAC_BITS-1:0] frac_mult;
    fpds_flags_t          flags;
  } fpds_res_t;

endpackage

FILE: rtl/frac_pll_divider_solver_core.sv
`timescale 1ns / 1ps
// Fractional-N PLL divider solver, top level.
// Depends on fpds_pkg and fpds_div_pipe.
//
// Usage:
//   cfg_we/cfg_wdata write the reference frequency (Hz, after the reference
//   divider); write it only while no transaction is in flight. Reset loads
//   6 MHz and empties the pipeline.
//   Each input transaction carries a requested output frequency; each output
//   transaction returns post divider code, integer and 24-bit fractional
//   multiplier, achieved frequency and three range flags.
//   Pipeline: 83 register stages: three front stages (divider pick, VCO
//   product, saturation check), 35 stages of the multiplier divider, two
//   stages of multiply and add, and 43 stages of the divider that scales
//   back by the post divider.
//   Throughput: one transaction per cycle while the receiver keeps taking
//   results; each divider retires one quotient bit per stage.
//   Every stage holds its own valid bit. When the receiver stalls, the
//   results stay in place and the stages behind the first empty one keep
//   filling, so in_ready drops only once the pipeline is full.
module frac_pll_divider_solver_core (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [fpds_pkg::REF_W-1:0]     cfg_wdata,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [fpds_pkg::RATE_W-1:0]    in_target_rate,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [fpds_pkg::CODE_W-1:0]    out_post_div_code,
  output logic [fpds_pkg::INT_W-1:0]     out_int_mult,
  output logic [fpds_pkg::FRAC_BITS-1:0] out_frac_mult,
  output logic [fpds_pkg::RATE_W-1:0]    out_achieved_rate,
  output logic                           out_out_range_bad,
  output logic                           out_ref_range_bad,
  output logic                           out_vco_range_bad
);

  localparam int MID_W = $bits(fpds_pkg::fpds_mid_t);
  localparam int RES_W = $bits(fpds_pkg::fpds_res_t);

  // Reference register
  logic [fpds_pkg::REF_W-1:0]   ref_r;
  logic [fpds_pkg::PRATE_W-1:0] prate;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ref_r <= fpds_pkg::REF_RESET;
    end else if (cfg_we) begin
      ref_r <= cfg_wdata;
    end
  end

  assign prate = {ref_r, 3'b000};

  // Stage 0: smallest post divider reaching the VCO minimum, else the largest
  logic [fpds_pkg::MAX_DIV_CODE-1:0] hit;
  logic [fpds_pkg::CODE_W-1:0]       code_nxt;
  fpds_pkg::fpds_flags_t             flags0_nxt;

  genvar c;
  generate
    for (c = 0; c < fpds_pkg::MAX_DIV_CODE; c++) begin : g_thr
      localparam longint unsigned D = longint'((c + 1) * 2);
      localparam logic [fpds_pkg::RATE_W-1:0] THR =
        fpds_pkg::RATE_W'((fpds_pkg::VCO_MIN_HZ + D - 1) / D);
      assign hit[c] = in_target_rate >= THR;
    end
  endgenerate

  always_comb begin
    code_nxt = fpds_pkg::CODE_W'(fpds_pkg::MAX_DIV_CODE);
    for (int i = fpds_pkg::MAX_DIV_CODE - 1; i >= 0; i--) begin
      if (hit[i]) begin
        code_nxt = fpds_pkg::CODE_W'(i);
      end
    end
  end

  always_comb begin
    flags0_nxt.out_bad = (in_target_rate < fpds_pkg::RATE_W'(fpds_pkg::OUT_MIN_HZ)) ||
                         (in_target_rate > fpds_pkg::RATE_W'(fpds_pkg::OUT_MAX_HZ));
    flags0_nxt.ref_bad = (ref_r < fpds_pkg::REF_W'(fpds_pkg::REF_MIN_HZ)) ||
                         (ref_r > fpds_pkg::REF_W'(fpds_pkg::REF_MAX_HZ));
    flags0_nxt.vco_bad = 1'b0;
  end

  logic                         s0_v_r;
  logic [fpds_pkg::RATE_W-1:0]  s0_rate_r;
  logic [fpds_pkg::CODE_W-1:0]  s0_code_r;
  fpds_pkg::fpds_flags_t        s0_flags_r;
  logic                         s0_en;

  // Stage 1: VCO frequency and its range flag
  logic                         s1_v_r;
  logic [fpds_pkg::VCO_W-1:0]   s1_vco_r;
  logic [fpds_pkg::CODE_W-1:0]  s1_code_r;
  fpds_pkg::fpds_flags_t        s1_flags_r;
  logic                         s1_en;
  logic [fpds_pkg::DIVQ_W-1:0]  divq;
  logic [fpds_pkg::VCO_W-1:0]   vco_nxt;
  fpds_pkg::fpds_flags_t        flags1_nxt;

  // Stage 2: saturation check and divider setup
  logic                         s2_v_r;
  logic [fpds_pkg::PRATE_W-1:0] s2_rem_r;
  logic [fpds_pkg::QUO_W-1:0]   s2_num_r;
  fpds_pkg::fpds_mid_t          s2_mid_r;
  logic                         s2_en;
  fpds_pkg::fpds_mid_t          mid_nxt;
  logic [fpds_pkg::PRATE_W-1:0] vco_hi;

  // Multiplier divider
  logic                         d1_in_ready;
  logic                         d1_out_valid;
  logic [fpds_pkg::QUO_W-1:0]   d1_quo;
  logic [MID_W-1:0]             d1_sb;
  fpds_pkg::fpds_mid_t          d1_mid;

  // Stage 3: saturate and multiply back
  logic                           s3_v_r;
  logic [fpds_pkg::PRODF_W-1:0]   s3_prodf_r;
  logic [fpds_pkg::PRODI_W-1:0]   s3_prodi_r;
  fpds_pkg::fpds_res_t            s3_res_r;
  logic                           s3_en;
  fpds_pkg::fpds_res_t            res_nxt;

  // Stage 4: sum and halve
  logic                           s4_v_r;
  logic [fpds_pkg::ACH_NUM_W-1:0] s4_num_r;
  fpds_pkg::fpds_res_t            s4_res_r;
  logic                           s4_en;
  logic [fpds_pkg::SUM_W-1:0]     sum;

  // Rate divider
  logic                           d2_in_ready;
  logic [fpds_pkg::ACH_NUM_W-1:0] d2_quo;
  logic [RES_W-1:0]               d2_sb;
  fpds_pkg::fpds_res_t            d2_res;

  // Stage enables: advance when empty or when the next stage takes it
  assign s4_en    = !s4_v_r || d2_in_ready;
  assign s3_en    = !s3_v_r || s4_en;
  assign s2_en    = !s2_v_r || d1_in_ready;
  assign s1_en    = !s1_v_r || s2_en;
  assign s0_en    = !s0_v_r || s1_en;
  assign in_ready = s0_en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_v_r <= 1'b0;
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
      s3_v_r <= 1'b0;
      s4_v_r <= 1'b0;
    end else begin
      if (s0_en) s0_v_r <= in_valid;
      if (s1_en) s1_v_r <= s0_v_r;
      if (s2_en) s2_v_r <= s1_v_r;
      if (s3_en) s3_v_r <= d1_out_valid;
      if (s4_en) s4_v_r <= s3_v_r;
    end
  end

  // Stage 0 payload
  always_ff @(posedge clk) begin
    if (s0_en && in_valid) begin
      s0_rate_r  <= in_target_rate;
      s0_code_r  <= code_nxt;
      s0_flags_r <= flags0_nxt;
    end
  end

  // Stage 1 logic and payload
  assign divq    = {(fpds_pkg::DEN2_W'(s0_code_r) + fpds_pkg::DEN2_W'(1)), 1'b0};
  assign vco_nxt = fpds_pkg::VCO_W'(s0_rate_r) * fpds_pkg::VCO_W'(divq);

  always_comb begin
    flags1_nxt         = s0_flags_r;
    flags1_nxt.vco_bad = (vco_nxt < fpds_pkg::VCO_W'(fpds_pkg::VCO_MIN_HZ)) ||
                         (vco_nxt > fpds_pkg::VCO_W'(fpds_pkg::VCO_MAX_HZ));
  end

  always_ff @(posedge clk) begin
    if (s1_en && s0_v_r) begin
      s1_vco_r   <= vco_nxt;
      s1_code_r  <= s0_code_r;
      s1_flags_r <= flags1_nxt;
    end
  end

  // Stage 2 logic and payload: quotient above the integer field means saturation
  assign vco_hi = fpds_pkg::PRATE_W'(s1_vco_r[fpds_pkg::VCO_W-1:fpds_pkg::INT_W]);

  always_comb begin
    mid_nxt.code  = s1_code_r;
    mid_nxt.flags = s1_flags_r;
    mid_nxt.sat   = vco_hi >= prate;
    mid_nxt.zero  = (ref_r == '0);
  end

  always_ff @(posedge clk) begin
    if (s2_en && s1_v_r) begin
      s2_rem_r <= vco_hi;
      s2_num_r <= {s1_vco_r[fpds_pkg::INT_W-1:0], {fpds_pkg::FRAC_BITS{1'b0}}};
      s2_mid_r <= mid_nxt;
    end
  end

  fpds_div_pipe #(
    .NUM_W (fpds_pkg::QUO_W),
    .DEN_W (fpds_pkg::PRATE_W),
    .SB_W  (MID_W)
  ) u_mult_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (s2_v_r),
    .in_ready  (d1_in_ready),
    .in_rem    (s2_rem_r),
    .in_num    (s2_num_r),
    .in_den    (prate),
    .in_sb     (s2_mid_r),
    .out_valid (d1_out_valid),
    .out_ready (s3_en),
    .out_quo   (d1_quo),
    .out_sb    (d1_sb)
  );

  assign d1_mid = fpds_pkg::fpds_mid_t'(d1_sb);

  // Stage 3 logic and payload: clamp, then multiply the reference back
  always_comb begin
    res_nxt.code  = d1_mid.code;
    res_nxt.flags = d1_mid.flags;
    priority if (d1_mid.zero) begin
      res_nxt.int_mult  = '0;
      res_nxt.frac_mult = '0;
    end else if (d1_mid.sat) begin
      res_nxt.int_mult  = '1;
      res_nxt.frac_mult = '1;
    end else begin
      res_nxt.int_mult  = d1_quo[fpds_pkg::QUO_W-1:fpds_pkg::FRAC_BITS];
      res_nxt.frac_mult = d1_quo[fpds_pkg::FRAC_BITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (s3_en && d1_out_valid) begin
      s3_prodf_r <= fpds_pkg::PRODF_W'(prate) * fpds_pkg::PRODF_W'(res_nxt.frac_mult);
      s3_prodi_r <= fpds_pkg::PRODI_W'(prate) * fpds_pkg::PRODI_W'(res_nxt.int_mult);
      s3_res_r   <= res_nxt;
    end
  end

  // Stage 4 logic and payload: drop divq's factor of two before dividing
  assign sum = fpds_pkg::SUM_W'(s3_prodf_r[fpds_pkg::PRODF_W-1:fpds_pkg::FRAC_BITS]) +
               fpds_pkg::SUM_W'(s3_prodi_r);

  always_ff @(posedge clk) begin
    if (s4_en && s3_v_r) begin
      s4_num_r <= sum[fpds_pkg::SUM_W-1:1];
      s4_res_r <= s3_res_r;
    end
  end

  fpds_div_pipe #(
    .NUM_W (fpds_pkg::ACH_NUM_W),
    .DEN_W (fpds_pkg::DEN2_W),
    .SB_W  (RES_W)
  ) u_rate_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (s4_v_r),
    .in_ready  (d2_in_ready),
    .in_rem    ('0),
    .in_num    (s4_num_r),
    .in_den    (fpds_pkg::DEN2_W'(s4_res_r.code) + fpds_pkg::DEN2_W'(1)),
    .in_sb     (s4_res_r),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_quo   (d2_quo),
    .out_sb    (d2_sb)
  );

  assign d2_res = fpds_pkg::fpds_res_t'(d2_sb);

  // Result fields
  assign out_post_div_code = d2_res.code;
  assign out_int_mult      = d2_res.int_mult;
  assign out_frac_mult     = d2_res.frac_mult;
  assign out_achieved_rate = d2_quo[fpds_pkg::RATE_W-1:0];
  assign out_out_range_bad = d2_res.flags.out_bad;
  assign out_ref_range_bad = d2_res.flags.ref_bad;
  assign out_vco_range_bad = d2_res.flags.vco_bad;

  // Checks
  a_s0_fill: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> s0_v_r)
    else $error("accepted transaction not captured in stage 0");

  a_s2_hold: assert property (@(posedge clk) disable iff (!rst_n)
    s2_v_r && !s2_en |=> s2_v_r && $stable(s2_num_r) && $stable(s2_mid_r))
    else $error("stage 2 changed while stalled");

  a_s4_hold: assert property (@(posedge clk) disable iff (!rst_n)
    s4_v_r && !s4_en |=> s4_v_r && $stable(s4_num_r))
    else $error("stage 4 changed while stalled");

endmodule

FILE: rtl/fpds_div_pipe.sv
`timescale 1ns / 1ps
// Pipelined restoring divider, one quotient bit per register stage.
// Depends on nothing but its parameters; each stage has its own valid/ready.
module fpds_div_pipe #(
  parameter int NUM_W = 35,
  parameter int DEN_W = 32,
  parameter int SB_W  = 8
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [DEN_W-1:0] in_rem,
  input  logic [NUM_W-1:0] in_num,
  input  logic [DEN_W-1:0] in_den,
  input  logic [SB_W-1:0]  in_sb,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [NUM_W-1:0] out_quo,
  output logic [SB_W-1:0]  out_sb
);

  logic             v_r   [NUM_W];
  logic [DEN_W-1:0] rem_r [NUM_W];
  logic [DEN_W-1:0] den_r [NUM_W];
  logic [NUM_W-1:0] num_r [NUM_W];
  logic [SB_W-1:0]  sb_r  [NUM_W];
  logic [NUM_W:0]   en;

  assign en[NUM_W] = out_ready;
  assign in_ready  = en[0];

  genvar k;
  generate
    for (k = 0; k < NUM_W; k++) begin : g_stage
      logic             src_v;
      logic [DEN_W-1:0] src_rem;
      logic [DEN_W-1:0] src_den;
      logic [NUM_W-1:0] src_num;
      logic [SB_W-1:0]  src_sb;
      logic [DEN_W:0]   trial;
      logic [DEN_W:0]   diff;
      logic             ge;
      logic [DEN_W-1:0] rem_nxt;
      logic [NUM_W-1:0] num_nxt;

      if (k == 0) begin : g_first
        assign src_v   = in_valid;
        assign src_rem = in_rem;
        assign src_den = in_den;
        assign src_num = in_num;
        assign src_sb  = in_sb;
      end else begin : g_next
        assign src_v   = v_r[k-1];
        assign src_rem = rem_r[k-1];
        assign src_den = den_r[k-1];
        assign src_num = num_r[k-1];
        assign src_sb  = sb_r[k-1];
      end

      // Shift in the next dividend bit, subtract when it fits
      assign trial   = {src_rem, src_num[NUM_W-1]};
      assign diff    = trial - {1'b0, src_den};
      assign ge      = trial >= {1'b0, src_den};
      assign rem_nxt = ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
      assign num_nxt = {src_num[NUM_W-2:0], ge};

      // Advance when empty or when the next stage takes this one
      assign en[k] = !v_r[k] || en[k+1];

      always_ff @(posedge clk) begin
        if (!rst_n) begin
          v_r[k] <= 1'b0;
        end else if (en[k]) begin
          v_r[k] <= src_v;
        end
      end

      always_ff @(posedge clk) begin
        if (en[k] && src_v) begin
          rem_r[k] <= rem_nxt;
          den_r[k] <= src_den;
          num_r[k] <= num_nxt;
          sb_r[k]  <= src_sb;
        end
      end
    end
  endgenerate

  assign out_valid = v_r[NUM_W-1];
  assign out_quo   = num_r[NUM_W-1];
  assign out_sb    = sb_r[NUM_W-1];

endmodule

FILE: tb/tb.sv
`timescale 1ns / 1ps
// Testbench for frac_pll_divider_solver_core: random and directed target rates
// under several reference settings, checked against an in-bench solver model.
// Depends on fpds_pkg and the core RTL.
module tb;

  localparam int LATENCY   = 83;
  localparam int WDOG_MAX  = 20000;

  typedef struct {
    logic [fpds_pkg::CODE_W-1:0]    code;
    logic [fpds_pkg::INT_W-1:0]     imult;
    logic [fpds_pkg::FRAC_BITS-1:0] fmult;
    logic [fpds_pkg::RATE_W-1:0]    achieved;
    logic                           out_bad;
    logic                           ref_bad;
    logic                           vco_bad;
  } solution_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [fpds_pkg::REF_W-1:0] cfg_wdata = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [fpds_pkg::RATE_W-1:0] in_target_rate = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [fpds_pkg::CODE_W-1:0] out_post_div_code;
  logic [fpds_pkg::INT_W-1:0] out_int_mult;
  logic [fpds_pkg::FRAC_BITS-1:0] out_frac_mult;
  logic [fpds_pkg::RATE_W-1:0] out_achieved_rate;
  logic out_out_range_bad, out_ref_range_bad, out_vco_range_bad;

  logic [fpds_pkg::RATE_W-1:0] pending_rates[$];
  solution_t                   expected_solutions[$];
  logic [fpds_pkg::REF_W-1:0]  ref_setting = fpds_pkg::REF_RESET;
  int                          fail_count = 0;
  int                          idle_cycles = 0;
  int                          send_gap = 0;
  int                          recv_gap = 0;
  bit                          long_stall_req = 1'b0;
  bit                          in_acc = 1'b0;

  frac_pll_divider_solver_core dut (.*);

  always #6 clk = ~clk;

  // Work out the divider settings for one target rate
  function automatic solution_t solve_divider(logic [fpds_pkg::RATE_W-1:0] rate,
                                              logic [fpds_pkg::REF_W-1:0] refr);
    solution_t s;
    longint unsigned code, divq, vco, p8, ip, fp, rem, ach;
    code = 0;
    while (code < fpds_pkg::MAX_DIV_CODE &&
           longint'(rate) * ((code + 1) * 2) < fpds_pkg::VCO_MIN_HZ)
      code++;
    divq = (code + 1) * 2;
    vco = longint'(rate) * divq;
    p8 = longint'(refr) * 8;
    ip = 0; fp = 0; ach = 0;
    if (p8 != 0) begin
      ip = vco / p8;
      if (ip > 2047) begin
        ip = 2047;
        fp = (64'd1 << fpds_pkg::FRAC_BITS) - 1;
      end else begin
        rem = vco - ip * p8;
        fp = ((rem << fpds_pkg::FRAC_BITS) / p8) & ((64'd1 << fpds_pkg::FRAC_BITS) - 1);
      end
      ach = (((p8 * fp) >> fpds_pkg::FRAC_BITS) + p8 * ip) / divq;
    end
    s.code = code[fpds_pkg::CODE_W-1:0];
    s.imult = ip[fpds_pkg::INT_W-1:0];
    s.fmult = fp[fpds_pkg::FRAC_BITS-1:0];
    s.achieved = ach[fpds_pkg::RATE_W-1:0];
    s.out_bad = (rate < fpds_pkg::OUT_MIN_HZ || rate > fpds_pkg::OUT_MAX_HZ);
    s.ref_bad = (refr < fpds_pkg::REF_MIN_HZ || refr > fpds_pkg::REF_MAX_HZ);
    s.vco_bad = (vco < fpds_pkg::VCO_MIN_HZ || vco > fpds_pkg::VCO_MAX_HZ);
    return s;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 95) return $urandom_range(1, 4);
    return $urandom_range(10, 60);
  endfunction

  function automatic logic [fpds_pkg::RATE_W-1:0] random_rate();
    case ($urandom_range(0, 5))
      0: return $urandom();
      1: return $urandom_range(31250000, 2000000000);
      2: return $urandom_range(0, 31250000);
      3: return $urandom_range(1, 2000);
      4: return 32'd2000000000 + $urandom_range(0, 4);
      default: return $urandom_range(31000000, 70000000);
    endcase
  endfunction

  // Record input acceptance at the rising edge and predict its result
  always @(posedge clk) begin
    in_acc <= 1'b0;
    if (rst_n && in_valid && in_ready) begin
      expected_solutions.push_back(solve_divider(in_target_rate, ref_setting));
      void'(pending_rates.pop_front());
      in_acc <= 1'b1;
    end
  end

  // Driver: offer queued transactions with random gaps
  always @(negedge clk) begin
    int g;
    if (rst_n) begin
      g = send_gap;
      if (in_acc) g = pick_gap();
      if (in_valid && !in_acc) begin
        // hold until accepted
      end else if (g > 0) begin
        in_valid <= 1'b0;
        g = g - 1;
      end else if (pending_rates.size() > 0) begin
        in_valid <= 1'b1;
        in_target_rate <= pending_rates[0];
      end else begin
        in_valid <= 1'b0;
      end
      send_gap <= g;
    end
  end

  // Receiver: random back-pressure, plus one long hold-off on request
  always @(negedge clk) begin
    if (rst_n) begin
      if (long_stall_req) begin
        long_stall_req <= 1'b0;
        recv_gap <= 400;
        out_ready <= 1'b0;
      end else if (recv_gap > 0) begin
        recv_gap <= recv_gap - 1;
        out_ready <= 1'b0;
      end else if ($urandom_range(0, 9) == 0) begin
        recv_gap <= pick_gap();
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Monitor: compare each result transaction with the oldest expectation
  always @(posedge clk) begin
    solution_t e;
    if (rst_n && out_valid && out_ready) begin
      if (expected_solutions.size() == 0) begin
        $error("unexpected result transaction");
        fail_count++;
      end else begin
        e = expected_solutions.pop_front();
        if (out_post_div_code !== e.code) begin
          $error("post_div_code exp %0d got %0d", e.code, out_post_div_code); fail_count++;
        end
        if (out_int_mult !== e.imult) begin
          $error("int_mult exp %0d got %0d", e.imult, out_int_mult); fail_count++;
        end
        if (out_frac_mult !== e.fmult) begin
          $error("frac_mult exp %0d got %0d", e.fmult, out_frac_mult); fail_count++;
        end
        if (out_achieved_rate !== e.achieved) begin
          $error("achieved_rate exp %0d got %0d", e.achieved, out_achieved_rate);
          fail_count++;
        end
        if (out_out_range_bad !== e.out_bad) begin
          $error("out_range_bad exp %0d got %0d", e.out_bad, out_out_range_bad); fail_count++;
        end
        if (out_ref_range_bad !== e.ref_bad) begin
          $error("ref_range_bad exp %0d got %0d", e.ref_bad, out_ref_range_bad); fail_count++;
        end
        if (out_vco_range_bad !== e.vco_bad) begin
          $error("vco_range_bad exp %0d got %0d", e.vco_bad, out_vco_range_bad); fail_count++;
        end
      end
    end
  end

  // Watchdog: cycles with no transaction on either side
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WDOG_MAX) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  task automatic wait_drained();
    while (pending_rates.size() > 0 || in_valid || expected_solutions.size() > 0)
      @(negedge clk);
    repeat (LATENCY + 5) @(negedge clk);
  endtask

  task automatic write_ref(logic [fpds_pkg::REF_W-1:0] v);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(negedge clk);
    cfg_we <= 1'b0;
    ref_setting = v;
  endtask

  task automatic random_phase(int n);
    repeat (n) pending_rates.push_back(random_rate());
  endtask

  logic [fpds_pkg::REF_W-1:0] ref_list[8] = '{29'd6000000, 29'd1000000, 29'd300000000,
                                             29'd5000000, 29'd7500000, 29'd4999999,
                                             29'd7500001, 29'd0};

  initial begin
    repeat (11) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    // Directed: field extremes, band edges, no-divider and saturating cases
    foreach (ref_list[i]) begin
      if (i != 0) write_ref(ref_list[i]);
      pending_rates.push_back(32'd0);
      pending_rates.push_back(32'hFFFFFFFF);
      pending_rates.push_back(32'd31250000);
      pending_rates.push_back(32'd31249999);
      pending_rates.push_back(32'd2000000000);
      pending_rates.push_back(32'd2000000001);
      pending_rates.push_back(32'd1000000000);
      pending_rates.push_back(32'd1);
      pending_rates.push_back(32'h55555555);
      pending_rates.push_back(32'hAAAAAAAA);
      if (i == 0) begin
        pending_rates.push_back(32'd62500000);
        pending_rates.push_back(32'd333333333);
        pending_rates.push_back(32'd1999999999);
      end
      wait_drained();
    end
    write_ref(fpds_pkg::REF_RESET);
    // Fill the pipeline behind a long receiver hold-off
    long_stall_req <= 1'b1;
    random_phase(300);
    wait_drained();
    // Random phases across reference settings
    for (int k = 0; k < 6; k++) begin
      case (k)
        0: write_ref(29'd6000000);
        1: write_ref(fpds_pkg::REF_W'($urandom_range(5000000, 7500000)));
        2: write_ref(fpds_pkg::REF_W'($urandom_range(1000000, 300000000)));
        3: write_ref(29'h1FFFFFFF);
        4: write_ref(fpds_pkg::REF_W'($urandom()));
        default: write_ref(29'd24000000);
      endcase
      random_phase(200);
      wait_drained();
    end
    if (fail_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end
endmodule

FILE: frac_pll_divider_solver_core.f
rtl/fpds_pkg.sv
rtl/fpds_div_pipe.sv
rtl/frac_pll_divider_solver_core.sv
tb/tb.sv
